>>> rtl/edfs_pkg.sv
// Shared types and constants for the EDF time-slice scheduler.
// Holds the transaction payload structs, command and register codes and the sequencer states.
// Has no dependencies; edfs_entry_update and the core refer to it by scoped names.
package edfs_pkg;

   localparam int CSR_DATA_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int ACTIVE_COUNT_WIDTH = 4;
   localparam int FRAME_WIDTH = 16;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CFG_ACTIVE_COUNT = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CFG_FRAME_LENGTH = 1'b1;

   // Field slots of one packed partition entry, counted from the LSB in units of TIME_BITS.
   localparam int NUM_FIELDS = 5;
   localparam int FIELD_ELAPSED = 0;
   localparam int FIELD_COUNTDOWN = 1;
   localparam int FIELD_REMAINING = 2;
   localparam int FIELD_PERIOD = 3;
   localparam int FIELD_BUDGET = 4;

   typedef struct packed {
      logic        cmd;
      logic [2:0]  entry_index;
      logic [15:0] budget;
      logic [15:0] period_len;
   } req_type;

   typedef struct packed {
      logic [2:0] slot_owner;
      logic       slot_idle;
      logic       frame_end;
   } rsp_type;

   typedef struct packed {
      logic eligible;
   } upd_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHARGE
   } state_type;

endpackage

>>> rtl/edfs_state_ram.sv
// Partition state memory: one write port and one read port with registered read data.
// Each word packs budget, period, remaining budget, deadline countdown and period position.
// Depends on nothing; instantiated by edf_time_slice_scheduler_core.
module edfs_state_ram #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 80
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/edfs_entry_update.sv
// Per-partition slot update: eligibility against the best deadline so far, countdown advance,
// replenishment at the period boundary and the charged copy of the entry.
// Depends on edfs_pkg; instantiated by edf_time_slice_scheduler_core.
module edfs_entry_update #(
   parameter int TIME_BITS = 16
) (
   input  logic [edfs_pkg::NUM_FIELDS*TIME_BITS-1:0] entry,
   input  logic [((TIME_BITS > 16) ? TIME_BITS : 16)-1:0] best_ddl,
   output logic [edfs_pkg::NUM_FIELDS*TIME_BITS-1:0] next_entry,
   output logic [edfs_pkg::NUM_FIELDS*TIME_BITS-1:0] charged_entry,
   output edfs_pkg::upd_status_type                 status
);

   localparam int CW = (TIME_BITS > 16) ? TIME_BITS : 16;

   logic [TIME_BITS-1:0] budget;
   logic [TIME_BITS-1:0] period;
   logic [TIME_BITS-1:0] remaining;
   logic [TIME_BITS-1:0] countdown;
   logic [TIME_BITS-1:0] elapsed;
   logic [TIME_BITS-1:0] next_remaining;
   logic [TIME_BITS-1:0] next_countdown;
   logic [TIME_BITS-1:0] next_elapsed;
   logic [TIME_BITS-1:0] charged_remaining;
   logic                 boundary;

   assign budget    = entry[edfs_pkg::FIELD_BUDGET*TIME_BITS +: TIME_BITS];
   assign period    = entry[edfs_pkg::FIELD_PERIOD*TIME_BITS +: TIME_BITS];
   assign remaining = entry[edfs_pkg::FIELD_REMAINING*TIME_BITS +: TIME_BITS];
   assign countdown = entry[edfs_pkg::FIELD_COUNTDOWN*TIME_BITS +: TIME_BITS];
   assign elapsed   = entry[edfs_pkg::FIELD_ELAPSED*TIME_BITS +: TIME_BITS];

   assign boundary = (elapsed == (period - TIME_BITS'(1)));

   always_comb begin
      if (boundary) begin
         next_remaining    = budget;
         next_countdown    = period;
         next_elapsed      = '0;
         charged_remaining = budget;
      end else begin
         next_remaining    = remaining;
         next_countdown    = (countdown != '0) ? countdown - TIME_BITS'(1) : countdown;
         next_elapsed      = elapsed + TIME_BITS'(1);
         charged_remaining = remaining - TIME_BITS'(1);
      end
   end

   assign next_entry    = {budget, period, next_remaining, next_countdown, next_elapsed};
   assign charged_entry = {budget, period, charged_remaining, next_countdown, next_elapsed};

   assign status.eligible = (remaining != '0) && (best_ddl >= CW'(countdown));

endmodule

>>> rtl/edf_time_slice_scheduler_core.sv
// Top level of the EDF time-slice scheduler: transaction handshakes, configuration registers,
// the sequencer that walks the partition state memory, and the result register.
// Depends on edfs_pkg, edfs_state_ram and edfs_entry_update.
//
// Usage: the request channel carries load and tick transactions on req_valid/req_stall with a
// req_payload struct. A load writes one partition's budget and period into the state memory and
// produces no result. A tick walks partitions 0 to n-1, where n is active_count limited to
// MAX_PARTITIONS, through the single read port of the state memory, one entry per cycle, picking
// the eligible entry with the smallest deadline countdown and writing each advanced entry back,
// then writes the charge to the chosen entry and loads the result onto rsp_valid/rsp_payload
// from the charge state. The next request is taken once the sequencer is back in idle, which a
// load never leaves. The result sits in an output register: new requests are accepted while it
// waits on rsp_stall, and a tick that finishes while the previous result is still stalled holds
// in its final state until the register frees up.
// Configuration is written on csr_we/csr_index/csr_wdata, by the user only while no transaction
// is in flight; the block itself does not enforce this.
// Synchronous reset returns the sequencer to idle, drops rsp_valid, clears the slot counter
// and sets active_count and frame_length to 1. Partition entries are not cleared; every
// active partition must be loaded before the first tick.
module edf_time_slice_scheduler_core #(
   parameter int MAX_PARTITIONS = 8,
   parameter int TIME_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  edfs_pkg::req_type                      req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output edfs_pkg::rsp_type                      rsp_payload,
   input  logic                                   csr_we,
   input  logic [edfs_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [edfs_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam int AW = $clog2(MAX_PARTITIONS);
   localparam int CNTW = $clog2(MAX_PARTITIONS + 1);
   localparam int CW = (TIME_BITS > 16) ? TIME_BITS : 16;
   localparam int EW = edfs_pkg::NUM_FIELDS * TIME_BITS;
   localparam int FW = edfs_pkg::FRAME_WIDTH;

   edfs_pkg::state_type                      state_ff, state_in;
   logic [edfs_pkg::ACTIVE_COUNT_WIDTH-1:0]  active_count_ff, active_count_in;
   logic [FW-1:0]                            frame_length_ff, frame_length_in;
   logic [FW-1:0]                            slot_counter_ff, slot_counter_in;
   logic [CNTW-1:0]                          n_ff, n_in;
   logic [FW-1:0]                            flen_ff, flen_in;
   logic [CNTW-1:0]                          rd_idx_ff, rd_idx_in;
   logic                                     rd_vld_ff, rd_vld_in;
   logic [AW-1:0]                            proc_idx_ff, proc_idx_in;
   logic [CW-1:0]                            best_ddl_ff, best_ddl_in;
   logic                                     found_ff, found_in;
   logic [AW-1:0]                            owner_ff, owner_in;
   logic [EW-1:0]                            owner_entry_ff, owner_entry_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   edfs_pkg::rsp_type                        rsp_payload_ff, rsp_payload_in;

   logic                     mem_we;
   logic [AW-1:0]            mem_waddr;
   logic [EW-1:0]            mem_wdata;
   logic                     mem_re;
   logic [AW-1:0]            mem_raddr;
   logic [EW-1:0]            mem_rdata;
   logic [EW-1:0]            upd_next;
   logic [EW-1:0]            upd_charged;
   edfs_pkg::upd_status_type upd_status;
   logic [TIME_BITS-1:0]     ld_budget;
   logic [TIME_BITS-1:0]     ld_period;
   logic                     frame_wrap;

   edfs_state_ram #(
      .DEPTH (MAX_PARTITIONS),
      .WIDTH (EW)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   edfs_entry_update #(
      .TIME_BITS (TIME_BITS)
   ) u_entry_update (
      .entry         (mem_rdata),
      .best_ddl      (best_ddl_ff),
      .next_entry    (upd_next),
      .charged_entry (upd_charged),
      .status        (upd_status)
   );

   assign ld_budget = TIME_BITS'(req_payload.budget);
   assign ld_period = (TIME_BITS'(req_payload.period_len) == '0) ? TIME_BITS'(1)
                                                                  : TIME_BITS'(req_payload.period_len);
   assign frame_wrap = ({1'b0, slot_counter_ff} + (FW + 1)'(1)) >= {1'b0, flen_ff};

   always_comb begin
      state_in        = state_ff;
      active_count_in = active_count_ff;
      frame_length_in = frame_length_ff;
      slot_counter_in = slot_counter_ff;
      n_in            = n_ff;
      flen_in         = flen_ff;
      rd_idx_in       = rd_idx_ff;
      proc_idx_in     = rd_idx_ff[AW-1:0];
      best_ddl_in     = best_ddl_ff;
      found_in        = found_ff;
      owner_in        = owner_ff;
      owner_entry_in  = owner_entry_ff;
      rsp_valid_in    = rsp_valid_ff & rsp_stall;
      rsp_payload_in  = rsp_payload_ff;
      mem_we          = 1'b0;
      mem_waddr       = proc_idx_ff;
      mem_wdata       = upd_next;
      mem_re          = 1'b0;
      mem_raddr       = rd_idx_ff[AW-1:0];
      req_stall       = (state_ff != edfs_pkg::ST_IDLE);

      if (csr_we) begin
         case (csr_index)
            edfs_pkg::CFG_ACTIVE_COUNT: begin
               active_count_in = csr_wdata[edfs_pkg::ACTIVE_COUNT_WIDTH-1:0];
            end
            edfs_pkg::CFG_FRAME_LENGTH: begin
               frame_length_in = csr_wdata[FW-1:0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         edfs_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_payload.cmd == edfs_pkg::CMD_LOAD) begin
                  if (32'(req_payload.entry_index) < MAX_PARTITIONS) begin
                     mem_we    = 1'b1;
                     mem_waddr = AW'(req_payload.entry_index);
                     mem_wdata = {ld_budget, ld_period, ld_budget, ld_period, TIME_BITS'(0)};
                  end
               end else begin
                  n_in        = (32'(active_count_ff) > MAX_PARTITIONS) ? CNTW'(MAX_PARTITIONS)
                                                                        : CNTW'(active_count_ff);
                  flen_in     = (frame_length_ff == '0) ? FW'(1) : frame_length_ff;
                  best_ddl_in = CW'(flen_in);
                  rd_idx_in   = '0;
                  found_in    = 1'b0;
                  owner_in    = '0;
                  state_in    = edfs_pkg::ST_SCAN;
               end
            end
         end
         edfs_pkg::ST_SCAN: begin
            if (rd_idx_ff != n_ff) begin
               mem_re    = 1'b1;
               rd_idx_in = rd_idx_ff + CNTW'(1);
            end
            if (rd_vld_ff) begin
               mem_we = 1'b1;
               if (upd_status.eligible) begin
                  best_ddl_in    = CW'(mem_rdata[edfs_pkg::FIELD_COUNTDOWN*TIME_BITS +: TIME_BITS]);
                  owner_in       = proc_idx_ff;
                  found_in       = 1'b1;
                  owner_entry_in = upd_charged;
               end
            end
            if ((rd_idx_ff == n_ff) && !rd_vld_ff) begin
               state_in = edfs_pkg::ST_CHARGE;
            end
         end
         edfs_pkg::ST_CHARGE: begin
            mem_we    = found_ff;
            mem_waddr = owner_ff;
            mem_wdata = owner_entry_ff;
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_payload_in.slot_owner = found_ff ? 3'(owner_ff) : 3'd0;
               rsp_payload_in.slot_idle  = !found_ff;
               rsp_payload_in.frame_end  = frame_wrap;
               slot_counter_in           = frame_wrap ? '0 : slot_counter_ff + FW'(1);
               state_in                  = edfs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = edfs_pkg::ST_IDLE;
         end
      endcase

      rd_vld_in = mem_re;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= edfs_pkg::ST_IDLE;
         active_count_ff <= edfs_pkg::ACTIVE_COUNT_WIDTH'(1);
         frame_length_ff <= FW'(1);
         slot_counter_ff <= '0;
         rd_vld_ff       <= 1'b0;
         found_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         active_count_ff <= active_count_in;
         frame_length_ff <= frame_length_in;
         slot_counter_ff <= slot_counter_in;
         rd_vld_ff       <= rd_vld_in;
         found_ff        <= found_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff           <= n_in;
      flen_ff        <= flen_in;
      rd_idx_ff      <= rd_idx_in;
      proc_idx_ff    <= proc_idx_in;
      best_ddl_ff    <= best_ddl_in;
      owner_ff       <= owner_in;
      owner_entry_ff <= owner_entry_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // A write-back during the walk must never hit the entry being fetched in the same cycle.
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (mem_re && mem_we) |-> (mem_raddr != mem_waddr))
      else $error("state memory read and write address collide");

   // The chosen partition always lies inside the active range of the current tick.
   a_owner_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == edfs_pkg::ST_CHARGE && found_ff) |-> (CNTW'(owner_ff) < n_ff))
      else $error("granted partition outside the active range");

   // A new result is only ever loaded from the final sequencer state.
   a_rsp_from_charge: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == edfs_pkg::ST_CHARGE))
      else $error("result raised outside the charge state");

   // The walk ends only after the last fetched entry has been written back.
   a_scan_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == edfs_pkg::ST_SCAN && state_in == edfs_pkg::ST_CHARGE)
         |-> (!rd_vld_ff && rd_idx_ff == n_ff))
      else $error("scan left with a fetch still outstanding");

endmodule
